### src/rxs_pkg.sv
// ----------------------------------------------------------------------------
// rxs_pkg: shared types and constants
// Record store sizing, record layout and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int TAG_BITS    = 16;
  localparam int SCORE_BITS  = 10;
  localparam int POS_BITS    = 5;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]   tag;
  } rec_t;

  // controller -> datapath
  typedef struct packed {
    logic             wr_en;
    logic             wr_src_cur;  // 1: write held record, 0: write input word
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_cur;    // held record <= read data
    logic             emit;
    logic [IDX_W-1:0] emit_pos;
    logic             emit_end;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic less;  // held score < read score
  } stat_t;

endpackage

### src/rxs_dpath.sv
// ----------------------------------------------------------------------------
// rxs_dpath: record store and compare datapath
// Record memory with one write and one registered read port, the held
// record register, the score compare and the result output registers.
// ----------------------------------------------------------------------------
module rxs_dpath
  import rxs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  input  logic [SCORE_BITS-1:0] score,
  input  logic [TAG_BITS-1:0]   tag,
  output logic                  valid,
  output logic [SCORE_BITS-1:0] sorted_score,
  output logic [TAG_BITS-1:0]   sorted_tag,
  output logic [POS_BITS-1:0]   position,
  output logic                  end_of_run
);

  rec_t mem [MAX_RECORDS];
  rec_t rd_data;
  rec_t cur;
  rec_t wr_data;

  assign wr_data   = cmd.wr_src_cur ? cur : rec_t'{score: score, tag: tag};
  assign stat.less = cur.score < rd_data.score;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  // held record and output payload
  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur <= rd_data;
    end
    if (cmd.emit) begin
      sorted_score <= rd_data.score;
      sorted_tag   <= rd_data.tag;
      position     <= POS_BITS'(cmd.emit_pos);
      end_of_run   <= cmd.emit_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  // no write and read of the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
    else $error("rxs_dpath: read and write hit the same entry");

  // a swap only writes the held record back
  a_swap_src: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.load_cur) |-> cmd.wr_src_cur)
    else $error("rxs_dpath: swap without held record as source");

  // strobe is registered from an emit command and rises in the cycle after it
  a_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> valid)
    else $error("rxs_dpath: missing result strobe");

endmodule

### src/rxs_ctrl.sv
// ----------------------------------------------------------------------------
// rxs_ctrl: load / sort / emit sequencer
// Counts incoming records, walks the exchange pattern over the store with
// the i and j counters, then reads out every record in rank order.
// ----------------------------------------------------------------------------
module rxs_ctrl
  import rxs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  last,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDI,
    S_LDI,
    S_RDJ,
    S_CMP,
    S_WRI,
    S_RDK,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             accept;
  logic [CNT_W-1:0] n_next;
  logic [CNT_W-1:0] n_last;
  logic             close;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign n_next = n + CNT_W'(1);
  assign n_last = n - CNT_W'(1);
  assign close  = last || (n_next == CNT_W'(MAX_RECORDS));

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.wr_en   = accept;
        cmd.wr_addr = n[IDX_W-1:0];
      end
      S_RDI: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = i;
      end
      S_LDI: begin
        cmd.load_cur = 1'b1;
      end
      S_RDJ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = j;
      end
      S_CMP: begin
        cmd.wr_en      = stat.less;
        cmd.wr_src_cur = 1'b1;
        cmd.wr_addr    = j;
        cmd.load_cur   = stat.less;
      end
      S_WRI: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_src_cur = 1'b1;
        cmd.wr_addr    = i;
      end
      S_RDK: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = k;
      end
      S_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.emit_pos = k;
        cmd.emit_end = ({1'b0, k} == n_last);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            n <= n_next;
            i <= '0;
            k <= '0;
            if (close) begin
              state <= (n_next == CNT_W'(1)) ? S_RDK : S_RDI;
            end
          end
        end
        S_RDI: begin
          state <= S_LDI;
        end
        S_LDI: begin
          j     <= i + IDX_W'(1);
          state <= S_RDJ;
        end
        S_RDJ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if ({1'b0, j} == n_last) begin
            state <= S_WRI;
          end else begin
            j     <= j + IDX_W'(1);
            state <= S_RDJ;
          end
        end
        S_WRI: begin
          if ({1'b0, i} + CNT_W'(1) == n_last) begin
            state <= S_RDK;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_RDI;
          end
        end
        S_RDK: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if ({1'b0, k} == n_last) begin
            n     <= '0;
            state <= S_IDLE;
          end else begin
            k     <= k + IDX_W'(1);
            state <= S_RDK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_RECORDS))
    else $error("rxs_ctrl: record count beyond store size");

  a_j_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((i < j) && ({1'b0, j} < n)))
    else $error("rxs_ctrl: compare index out of range");

  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> busy)
    else $error("rxs_ctrl: closing word did not start sorting");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ({1'b0, k} < n))
    else $error("rxs_ctrl: emit index past record count");

endmodule

### src/record_exchange_sort_desc.sv
// ----------------------------------------------------------------------------
// record_exchange_sort_desc: descending exchange sort of score/tag records
// Loads records, sorts them by descending score on the closing word, then
// streams them out in rank order.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a word (score, tag, last) is taken on a rising edge with start high
//   and busy low. Each word is written to the record store as it is taken.
//   A word with last set, or the word that fills the 32-entry store, closes
//   the set: busy rises and the block sorts, then emits.
//   Sort: the record at rank i is held in a register while the store is
//   walked over j = i+1 .. n-1; a larger score swaps into the register and
//   the held record is written back at j. Each compare is a registered
//   memory read, then a compare/write; each outer pass adds a read and load
//   of the held record at i and its write-back at i.
//   Output: each result word is on sorted_score, sorted_tag, position and
//   end_of_run for one cycle with valid high; each word is read from the
//   store before it is issued, end_of_run on the last. The receiver cannot
//   stall; busy falls after the final word is issued and a new set may load
//   while it is shown. Every record use waits on the registered store read.
//   Reset: clears the sequencer and record count; store contents stay
//   undefined and only entries written in the current set are ever read.
// ----------------------------------------------------------------------------
module record_exchange_sort_desc
  import rxs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [SCORE_BITS-1:0] score,
  input  logic [TAG_BITS-1:0]   tag,
  input  logic                  last,
  output logic                  valid,
  output logic [SCORE_BITS-1:0] sorted_score,
  output logic [TAG_BITS-1:0]   sorted_tag,
  output logic [POS_BITS-1:0]   position,
  output logic                  end_of_run
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: counts records, drives store addresses and emit
  rxs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (last),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // store, held record, compare and result registers
  rxs_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .score        (score),
    .tag          (tag),
    .valid        (valid),
    .sorted_score (sorted_score),
    .sorted_tag   (sorted_tag),
    .position     (position),
    .end_of_run   (end_of_run)
  );

endmodule
